/* sv/wsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg
// shared types and constants of the wlan security classifier
// ----------------------------------------------------------------------------
package wsc_pkg;

  // register map
  localparam int unsigned AddrWidth = 3;
  localparam logic        RegRsnId  = 1'b0;
  localparam logic        RegVndId  = 1'b1;

  localparam logic [7:0] RsnIdReset = 8'd48;
  localparam logic [7:0] VndIdReset = 8'd221;

  // element kinds
  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindRsn   = 2'd1;
  localparam logic [1:0] KindWpa   = 2'd2;

  // akm suite oui match state
  localparam logic [1:0] OuiUnknown = 2'd0;
  localparam logic [1:0] OuiMs      = 2'd1;
  localparam logic [1:0] OuiIeee    = 2'd2;
  localparam logic [1:0] OuiPending = 2'd3;

  // verdict codes
  localparam logic [2:0] ClsNone    = 3'd0;
  localparam logic [2:0] ClsWep     = 3'd1;
  localparam logic [2:0] ClsWpaPsk  = 3'd2;
  localparam logic [2:0] ClsWpa2Psk = 3'd3;
  localparam logic [2:0] ClsWpaEnt  = 3'd4;
  localparam logic [2:0] ClsWpa2Ent = 3'd5;

  // suite list offsets inside an element (counted from the id byte)
  localparam logic [8:0] RsnSuiteOfs = 9'd8;
  localparam logic [8:0] WpaSuiteOfs = 9'd12;

  // oui bytes
  localparam logic [7:0] OuiMsB1   = 8'h50;
  localparam logic [7:0] OuiMsB2   = 8'hf2;
  localparam logic [7:0] OuiIeeeB1 = 8'h0f;
  localparam logic [7:0] OuiIeeeB2 = 8'hac;

  localparam logic [7:0] AkmPsk   = 8'd2;
  localparam logic [7:0] AkmFtPsk = 8'd4;

  typedef struct packed {
    logic       last_byte;
    logic       first_byte;
    logic       privacy_bit;
    logic [7:0] ie_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] rsn_id;
    logic [7:0] vnd_id;
  } cfg_t;

  // wpa header after the length byte: oui 00:50:f2, type 1
  function automatic logic [7:0] wpa_hdr(input logic [1:0] idx);
    logic [7:0] res;
    case (idx)
      2'd0:    res = 8'h00;
      2'd1:    res = 8'h50;
      2'd2:    res = 8'hf2;
      default: res = 8'h01;
    endcase
    return res;
  endfunction

endpackage

/* sv/wsc_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_apb_regs
// apb register file holding the two element id registers
// ----------------------------------------------------------------------------
module wsc_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output wsc_pkg::cfg_t                 cfg_o
);

  logic [7:0] rsn_id_q, rsn_id_d;
  logic [7:0] vnd_id_q, vnd_id_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    rsn_id_d = rsn_id_q;
    vnd_id_d = vnd_id_q;
    if (wr_en) begin
      unique case (paddr[2])
        wsc_pkg::RegRsnId: rsn_id_d = pwdata[7:0];
        wsc_pkg::RegVndId: vnd_id_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      wsc_pkg::RegRsnId: prdata = {24'h0, rsn_id_q};
      wsc_pkg::RegVndId: prdata = {24'h0, vnd_id_q};
      default:           prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsn_id_q <= wsc_pkg::RsnIdReset;
      vnd_id_q <= wsc_pkg::VndIdReset;
    end else begin
      rsn_id_q <= rsn_id_d;
      vnd_id_q <= vnd_id_d;
    end
  end

  assign cfg_o.rsn_id = rsn_id_q;
  assign cfg_o.vnd_id = vnd_id_q;

endmodule

/* sv/wsc_elem_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_elem_parser
// element walker: tracks rsn/wpa suite counts and akm selector, keeps verdict
// ----------------------------------------------------------------------------
module wsc_elem_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  wsc_pkg::item_t item_i,
  input  wsc_pkg::cfg_t  cfg_i,
  output logic [2:0]     cls_o
);

  logic [8:0]  pos_q, pos_s, pos_d;
  logic [7:0]  len_q, len_s, len_d;
  logic [1:0]  kind_q, kind_s, kind_d;
  logic [15:0] pw_q, pw_s, pw_d;
  logic [15:0] akm_q, akm_s, akm_d;
  logic [1:0]  oui_q, oui_s, oui_d;
  logic [7:0]  styp_q, styp_s, styp_d;
  logic [2:0]  verd_q, verd_s, verd_d;
  logic        fin;

  logic [7:0]  v;
  logic [8:0]  ofs_p;
  logic [18:0] base, pos_w;

  logic [8:0]  ofs_j, tot, l9;
  logic [18:0] need, akm_need, l_w, r_w;
  logic        ent;

  assign v = item_i.ie_byte;

  // start state: a first byte restarts the record
  always_comb begin
    if (item_i.first_byte) begin
      pos_s  = '0;
      len_s  = '0;
      kind_s = wsc_pkg::KindOther;
      pw_s   = '0;
      akm_s  = '0;
      oui_s  = wsc_pkg::OuiUnknown;
      styp_s = '0;
      verd_s = item_i.privacy_bit ? wsc_pkg::ClsWep : wsc_pkg::ClsNone;
    end else begin
      pos_s  = pos_q;
      len_s  = len_q;
      kind_s = kind_q;
      pw_s   = pw_q;
      akm_s  = akm_q;
      oui_s  = oui_q;
      styp_s = styp_q;
      verd_s = verd_q;
    end
  end

  // byte walk
  always_comb begin
    pos_d  = pos_s;
    len_d  = len_s;
    kind_d = kind_s;
    pw_d   = pw_s;
    akm_d  = akm_s;
    oui_d  = oui_s;
    styp_d = styp_s;
    fin    = 1'b0;
    ofs_p  = wsc_pkg::WpaSuiteOfs;
    pos_w  = {10'b0, pos_s};
    base   = '0;
    if (pos_s == 9'd0) begin
      if (v == cfg_i.rsn_id) begin
        kind_d = wsc_pkg::KindRsn;
      end else if (v == cfg_i.vnd_id) begin
        kind_d = wsc_pkg::KindWpa;
      end else begin
        kind_d = wsc_pkg::KindOther;
      end
      pw_d   = '0;
      akm_d  = '0;
      oui_d  = wsc_pkg::OuiUnknown;
      styp_d = '0;
      pos_d  = 9'd1;
    end else if (pos_s == 9'd1) begin
      len_d = v;
      if (v == 8'd0) begin
        fin = 1'b1;
      end else begin
        pos_d = 9'd2;
      end
    end else begin
      // wpa header check on bytes 2..5
      if (kind_s == wsc_pkg::KindWpa && pos_s <= 9'd5) begin
        if (v != wsc_pkg::wpa_hdr(pos_s[1:0] - 2'd2)) begin
          kind_d = wsc_pkg::KindOther;
        end
      end
      ofs_p = (kind_d == wsc_pkg::KindRsn) ? wsc_pkg::RsnSuiteOfs : wsc_pkg::WpaSuiteOfs;
      base  = {10'b0, ofs_p} + 19'd2 + {1'b0, pw_s, 2'b00};
      if (kind_d != wsc_pkg::KindOther) begin
        if (pos_s == ofs_p) begin
          pw_d = {8'h00, v};
        end else if (pos_s == ofs_p + 9'd1) begin
          pw_d = pw_s | {v, 8'h00};
        end else if (pos_s >= ofs_p + 9'd2) begin
          if (pos_w == base) begin
            akm_d = {8'h00, v};
          end else if (pos_w == base + 19'd1) begin
            akm_d = akm_s | {v, 8'h00};
          end else if (pos_w == base + 19'd2) begin
            oui_d = (v == 8'h00) ? wsc_pkg::OuiPending : wsc_pkg::OuiUnknown;
          end else if (pos_w == base + 19'd3) begin
            if (oui_s == wsc_pkg::OuiPending && v == wsc_pkg::OuiMsB1) begin
              oui_d = wsc_pkg::OuiMs;
            end else if (oui_s == wsc_pkg::OuiPending && v == wsc_pkg::OuiIeeeB1) begin
              oui_d = wsc_pkg::OuiIeee;
            end else begin
              oui_d = wsc_pkg::OuiUnknown;
            end
          end else if (pos_w == base + 19'd4) begin
            if (!((oui_s == wsc_pkg::OuiMs && v == wsc_pkg::OuiMsB2) ||
                  (oui_s == wsc_pkg::OuiIeee && v == wsc_pkg::OuiIeeeB2))) begin
              oui_d = wsc_pkg::OuiUnknown;
            end
          end else if (pos_w == base + 19'd5) begin
            styp_d = v;
          end
        end
      end
      if (pos_s >= {1'b0, len_s} + 9'd1) begin
        fin = 1'b1;
      end else begin
        pos_d = pos_s + 9'd1;
      end
    end
    if (fin) begin
      pos_d = '0;
    end
  end

  // personal / enterprise decision on the updated element state
  always_comb begin
    ofs_j    = (kind_d == wsc_pkg::KindRsn) ? wsc_pkg::RsnSuiteOfs : wsc_pkg::WpaSuiteOfs;
    tot      = {1'b0, len_d} + 9'd2;
    l9       = (tot >= ofs_j) ? tot - ofs_j : 9'd0;
    l_w      = {10'b0, l9};
    need     = 19'd2 + {1'b0, pw_d, 2'b00};
    akm_need = 19'd2 + {1'b0, akm_d, 2'b00};
    r_w      = l_w - need;
    if (need > l_w) begin
      ent = 1'b0;
    end else if (r_w < 19'd2) begin
      ent = 1'b1;
    end else if (akm_need > r_w) begin
      ent = 1'b0;
    end else if (r_w < 19'd6) begin
      ent = 1'b1;
    end else if (oui_d == wsc_pkg::OuiMs) begin
      ent = (styp_d != wsc_pkg::AkmPsk);
    end else if (oui_d == wsc_pkg::OuiIeee) begin
      ent = !(styp_d == wsc_pkg::AkmPsk || styp_d == wsc_pkg::AkmFtPsk);
    end else begin
      ent = 1'b1;
    end
  end

  always_comb begin
    verd_d = verd_s;
    if (fin) begin
      if (kind_d == wsc_pkg::KindRsn) begin
        verd_d = ent ? wsc_pkg::ClsWpa2Ent : wsc_pkg::ClsWpa2Psk;
      end else if (kind_d == wsc_pkg::KindWpa && len_d >= 8'd4) begin
        verd_d = ent ? wsc_pkg::ClsWpaEnt : wsc_pkg::ClsWpaPsk;
      end
    end
  end

  assign cls_o = verd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      kind_q <= wsc_pkg::KindOther;
      pw_q   <= '0;
      akm_q  <= '0;
      oui_q  <= wsc_pkg::OuiUnknown;
      styp_q <= '0;
      verd_q <= wsc_pkg::ClsNone;
    end else if (fire_i) begin
      if (item_i.last_byte) begin
        pos_q  <= '0;
        len_q  <= '0;
        kind_q <= wsc_pkg::KindOther;
        pw_q   <= '0;
        akm_q  <= '0;
        oui_q  <= wsc_pkg::OuiUnknown;
        styp_q <= '0;
        verd_q <= wsc_pkg::ClsNone;
      end else begin
        pos_q  <= pos_d;
        len_q  <= len_d;
        kind_q <= kind_d;
        pw_q   <= pw_d;
        akm_q  <= akm_d;
        oui_q  <= oui_d;
        styp_q <= styp_d;
        verd_q <= verd_d;
      end
    end
  end

endmodule

/* sv/wlan_security_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlan_security_classifier
// classifies a scanned network as none/wep/wpa/wpa2, personal or enterprise
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries the information-element area one byte per transfer;
//   tuser[0] is the capability privacy bit (sampled on the first byte),
//   tuser[1] marks the first byte of a record and tlast the final byte.
//   m_axis gives one transfer per record, on its last byte, holding the
//   security class in tdata[2:0].
//   a byte is registered on accept and walked from the input register; a
//   last byte's verdict is registered in the output register that drives
//   m_axis. throughput: one byte per cycle while no last byte waits on a
//   full output register; the element walker updates its state in a single
//   pass, which sets the rate.
//   a stalled receiver only holds back a last byte while a verdict is still
//   waiting in the output register; bytes ahead of it keep flowing, then
//   s_axis_tready stays low until the waiting verdict leaves.
//   reset clears the walker, the verdict and both valid flags; the element
//   id registers return to 48 (rsn) and 221 (vendor).
//   the apb port holds the rsn id at 0x0 and the vendor id at 0x4; write
//   them only while no record is in flight.
// ----------------------------------------------------------------------------
module wlan_security_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] ie_byte
  input  logic [1:0]                    s_axis_tuser,  // [0] privacy_bit, [1] first_byte
  input  logic                          s_axis_tlast,  // last_byte
  // verdict stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [2:0] security_class, rest zero
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  wsc_pkg::cfg_t  cfg;
  wsc_pkg::item_t in_q, in_d;
  logic           in_vld_q, in_vld_d;
  logic           out_vld_q, out_vld_d;
  logic [2:0]     out_cls_q, out_cls_d;
  logic           proc_fire;
  logic [2:0]     cls;

  wsc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a held byte is walked unless it is a last byte that finds the output full and not being taken
  assign proc_fire     = in_vld_q & (~in_q.last_byte | ~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | proc_fire;

  // input register
  always_comb begin
    in_d     = in_q;
    in_vld_d = in_vld_q & ~proc_fire;
    if (s_axis_tvalid && s_axis_tready) begin
      in_d.ie_byte     = s_axis_tdata;
      in_d.privacy_bit = s_axis_tuser[0];
      in_d.first_byte  = s_axis_tuser[1];
      in_d.last_byte   = s_axis_tlast;
      in_vld_d         = 1'b1;
    end
  end

  wsc_elem_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc_fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .cls_o  (cls)
  );

  // result register
  always_comb begin
    out_vld_d = out_vld_q & ~m_axis_tready;
    out_cls_d = out_cls_q;
    if (proc_fire && in_q.last_byte) begin
      out_vld_d = 1'b1;
      out_cls_d = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    out_cls_q <= out_cls_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_cls_q};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the wlan security classifier: builds network records
// out of rsn, wpa and other elements, streams them in a byte at a time with
// random gaps and receiver stalls, predicts each verdict with a bit-accurate
// software copy of the element walker and compares every verdict transfer.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit  = 500000;
  localparam int HoldCycles  = 200;  // long receiver hold-off
  localparam int SettleCycles = 4;

  // first akm suite flavor used by the element builder
  localparam int OuiSelMs     = 0;
  localparam int OuiSelIeee   = 1;
  localparam int OuiSelRandom = 2;

  localparam logic [7:0] OuiByte0   = 8'h00;
  localparam logic [7:0] WpaOuiType = 8'h01;
  localparam logic [7:0] AkmDot1x   = 8'd1;
  localparam logic [7:0] CipherCcmp = 8'd4;
  // wpa vendor header bytes, lowest byte first
  localparam logic [31:0] WpaHdrBytes = {WpaOuiType, wsc_pkg::OuiMsB2, wsc_pkg::OuiMsB1,
                                         OuiByte0};

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;
  logic [1:0]                    s_axis_tuser = '0;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [wsc_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  wlan_security_classifier dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  int         error_cnt = 0;
  int         cycle_cnt = 0;
  int         items_sent = 0;
  logic [2:0] verdict_q[$];   // verdicts still owed by the block, oldest first
  logic [7:0] rec_q[$];       // bytes of the record being assembled
  bit         tx_quiet = 1'b0;
  bit         rx_quiet = 1'b0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         stall_left = 0;

  // --------------------------------------------------------------------------
  // verdict predictor: its own copy of the id registers and the walker state
  // --------------------------------------------------------------------------
  logic [7:0]  rsn_id_cfg = wsc_pkg::RsnIdReset;
  logic [7:0]  vnd_id_cfg = wsc_pkg::VndIdReset;
  logic [8:0]  walk_pos;
  logic [7:0]  elem_len;
  logic [1:0]  elem_kind;
  logic [15:0] pair_cnt;
  logic [15:0] akm_cnt;
  logic [1:0]  akm_oui;
  logic [7:0]  akm_suite;
  logic [2:0]  verdict;

  function automatic void clear_walk();
    walk_pos  = '0;
    elem_len  = '0;
    elem_kind = wsc_pkg::KindOther;
    pair_cnt  = '0;
    akm_cnt   = '0;
    akm_oui   = wsc_pkg::OuiUnknown;
    akm_suite = '0;
  endfunction

  // element byte index of the pairwise count
  function automatic int unsigned suite_ofs();
    return (elem_kind == wsc_pkg::KindRsn) ? wsc_pkg::RsnSuiteOfs : wsc_pkg::WpaSuiteOfs;
  endfunction

  function automatic logic enterprise_akm();
    int unsigned total, avail, need, rest;
    total = elem_len + 2;
    avail = (total >= suite_ofs()) ? total - suite_ofs() : 0;
    need  = 2 + 4 * pair_cnt;
    if (need > avail) return 1'b0;
    rest = avail - need;
    // no akm list at all means 802.1x
    if (rest < 2) return 1'b1;
    if (2 + 4 * akm_cnt > rest) return 1'b0;
    // count present but the first suite does not fit
    if (rest < 6) return 1'b1;
    if (akm_oui == wsc_pkg::OuiMs) return akm_suite != wsc_pkg::AkmPsk;
    if (akm_oui == wsc_pkg::OuiIeee)
      return !(akm_suite == wsc_pkg::AkmPsk || akm_suite == wsc_pkg::AkmFtPsk);
    return 1'b1;
  endfunction

  function automatic void close_element();
    if (elem_kind == wsc_pkg::KindRsn) begin
      verdict = enterprise_akm() ? wsc_pkg::ClsWpa2Ent : wsc_pkg::ClsWpa2Psk;
    end else if (elem_kind == wsc_pkg::KindWpa && elem_len >= 4) begin
      verdict = enterprise_akm() ? wsc_pkg::ClsWpaEnt : wsc_pkg::ClsWpaPsk;
    end
    walk_pos = '0;
  endfunction

  function automatic void walk_payload(input logic [7:0] v, input int unsigned p);
    int unsigned ofs, base;
    // vendor element must carry the wpa oui and type right after the length
    if (elem_kind == wsc_pkg::KindWpa && p <= 5) begin
      if (v != WpaHdrBytes[8 * ((p - 2) % 4) +: 8]) elem_kind = wsc_pkg::KindOther;
    end
    if (elem_kind == wsc_pkg::KindOther) return;
    ofs = suite_ofs();
    if (p == ofs) begin
      pair_cnt = {8'h00, v};
    end else if (p == ofs + 1) begin
      pair_cnt[15:8] = v;
    end else if (p >= ofs + 2) begin
      base = ofs + 2 + 4 * pair_cnt;
      if (p == base) begin
        akm_cnt = {8'h00, v};
      end else if (p == base + 1) begin
        akm_cnt[15:8] = v;
      end else if (p == base + 2) begin
        akm_oui = (v == OuiByte0) ? wsc_pkg::OuiPending : wsc_pkg::OuiUnknown;
      end else if (p == base + 3) begin
        if (akm_oui == wsc_pkg::OuiPending && v == wsc_pkg::OuiMsB1) begin
          akm_oui = wsc_pkg::OuiMs;
        end else if (akm_oui == wsc_pkg::OuiPending && v == wsc_pkg::OuiIeeeB1) begin
          akm_oui = wsc_pkg::OuiIeee;
        end else begin
          akm_oui = wsc_pkg::OuiUnknown;
        end
      end else if (p == base + 4) begin
        if (!((akm_oui == wsc_pkg::OuiMs && v == wsc_pkg::OuiMsB2) ||
              (akm_oui == wsc_pkg::OuiIeee && v == wsc_pkg::OuiIeeeB2)))
          akm_oui = wsc_pkg::OuiUnknown;
      end else if (p == base + 5) begin
        akm_suite = v;
      end
    end
  endfunction

  // one accepted byte; returns 1 with the verdict when the byte closes a record
  function automatic logic classify_byte(input wsc_pkg::item_t it, output logic [2:0] cls);
    int unsigned p;
    cls = wsc_pkg::ClsNone;
    if (it.first_byte) begin
      clear_walk();
      verdict = it.privacy_bit ? wsc_pkg::ClsWep : wsc_pkg::ClsNone;
    end
    p = walk_pos;
    if (p == 0) begin
      if (it.ie_byte == rsn_id_cfg) elem_kind = wsc_pkg::KindRsn;
      else if (it.ie_byte == vnd_id_cfg) elem_kind = wsc_pkg::KindWpa;
      else elem_kind = wsc_pkg::KindOther;
      pair_cnt  = '0;
      akm_cnt   = '0;
      akm_oui   = wsc_pkg::OuiUnknown;
      akm_suite = '0;
      walk_pos  = 9'd1;
    end else if (p == 1) begin
      elem_len = it.ie_byte;
      if (it.ie_byte == 8'd0) close_element();
      else walk_pos = 9'd2;
    end else begin
      walk_payload(it.ie_byte, p);
      if (p >= elem_len + 1) close_element();
      else walk_pos = 9'(p + 1);
    end
    if (it.last_byte) begin
      cls = verdict;
      clear_walk();
      verdict = wsc_pkg::ClsNone;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  initial begin
    clear_walk();
    verdict = wsc_pkg::ClsNone;
  end

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report(input string msg);
    $display("ERROR @%0d: %s", cycle_cnt, msg);
    error_cnt++;
  endtask

  // each verdict transfer against the oldest owed verdict
  always @(posedge clk_i) begin : check_verdict
    logic [2:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict %0d with none owed", m_axis_tdata[2:0]));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[2:0] !== want)
          report($sformatf("security_class %0d, expected %0d", m_axis_tdata[2:0], want));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout with %0d verdicts owed", verdict_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // verdict receiver: short random stalls, quiet stretches, one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left == 0 && hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 99) < 12) begin
      stall_left = int'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3)) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // byte sender
  // --------------------------------------------------------------------------
  function automatic int tx_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays high from one transfer to the next unless a gap comes
  task automatic send_byte(input wsc_pkg::item_t it);
    int gap;
    logic [2:0] cls;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.ie_byte;
    s_axis_tuser  <= {it.first_byte, it.privacy_bit};
    s_axis_tlast  <= it.last_byte;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (classify_byte(it, cls)) verdict_q.push_back(cls);
  endtask

  // sends the assembled record; opened=0 leaves out the first-byte flag
  task automatic send_record(input logic priv, input bit opened);
    wsc_pkg::item_t it;
    for (int i = 0; i < rec_q.size(); i++) begin
      it.ie_byte     = rec_q[i];
      it.first_byte  = opened && (i == 0);
      it.privacy_bit = it.first_byte ? priv : 1'($urandom_range(0, 1));
      it.last_byte   = (i == rec_q.size() - 1);
      send_byte(it);
    end
    rec_q.delete();
  endtask

  // sender pauses until every owed verdict is back, then lets the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // register access
  // --------------------------------------------------------------------------
  function automatic logic [wsc_pkg::AddrWidth-1:0] reg_addr(input logic idx);
    return {idx, 2'b00};
  endfunction

  task automatic apb_write(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= {24'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register taken at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == wsc_pkg::RegRsnId) rsn_id_cfg = val;
    else vnd_id_cfg = val;
  endtask

  task automatic apb_check(input logic idx, input logic [7:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[7:0] !== want)
      report($sformatf("register %0d reads %0d, expected %0d", idx, prdata[7:0], want));
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_ids(input logic [7:0] rsn, input logic [7:0] vnd);
    drain();
    apb_write(wsc_pkg::RegRsnId, rsn);
    apb_write(wsc_pkg::RegVndId, vnd);
    apb_check(wsc_pkg::RegRsnId, rsn);
    apb_check(wsc_pkg::RegVndId, vnd);
  endtask

  // --------------------------------------------------------------------------
  // record builders
  // --------------------------------------------------------------------------
  task automatic put_other(input logic [7:0] id, input int len);
    rec_q.push_back(id);
    rec_q.push_back(8'(len));
    repeat (len) rec_q.push_back(8'($urandom));
  endtask

  // rsn or wpa element; claimed counts may differ from the suites written,
  // akm_claim < 0 drops the akm list, bad_hdr >= 0 spoils one wpa header byte
  task automatic put_suite_elem(input bit wpa, input int pw_claim, input int pw_real,
                                input int akm_claim, input int akm_real, input int oui_sel,
                                input logic [7:0] akm_t, input int tail, input int len_adj,
                                input int bad_hdr);
    logic [7:0] body[$];
    int len;
    if (wpa) begin
      for (int i = 0; i < 4; i++) body.push_back(WpaHdrBytes[8 * i +: 8]);
      if (bad_hdr >= 0) body[bad_hdr] = body[bad_hdr] ^ 8'($urandom_range(1, 255));
    end
    // version 1, group cipher ccmp
    body.push_back(8'h01);
    body.push_back(8'h00);
    body.push_back(OuiByte0);
    body.push_back(wsc_pkg::OuiIeeeB1);
    body.push_back(wsc_pkg::OuiIeeeB2);
    body.push_back(CipherCcmp);
    body.push_back(pw_claim[7:0]);
    body.push_back(pw_claim[15:8]);
    repeat (pw_real) begin
      body.push_back(OuiByte0);
      body.push_back(wsc_pkg::OuiIeeeB1);
      body.push_back(wsc_pkg::OuiIeeeB2);
      body.push_back(CipherCcmp);
    end
    if (akm_claim >= 0) begin
      body.push_back(akm_claim[7:0]);
      body.push_back(akm_claim[15:8]);
      for (int i = 0; i < akm_real; i++) begin
        if (i == 0 && oui_sel == OuiSelMs) begin
          body.push_back(OuiByte0);
          body.push_back(wsc_pkg::OuiMsB1);
          body.push_back(wsc_pkg::OuiMsB2);
        end else if (i == 0 && oui_sel == OuiSelIeee) begin
          body.push_back(OuiByte0);
          body.push_back(wsc_pkg::OuiIeeeB1);
          body.push_back(wsc_pkg::OuiIeeeB2);
        end else begin
          // near misses of both ouis as well as noise
          body.push_back($urandom_range(0, 1) ? OuiByte0 : 8'($urandom));
          body.push_back($urandom_range(0, 1) ? wsc_pkg::OuiMsB1 : 8'($urandom));
          body.push_back($urandom_range(0, 1) ? wsc_pkg::OuiIeeeB2 : 8'($urandom));
        end
        body.push_back((i == 0) ? akm_t : 8'($urandom));
      end
    end
    repeat (tail) body.push_back(8'($urandom));
    len = body.size() + len_adj;
    if (len < 0) len = 0;
    if (len > 255) len = 255;
    rec_q.push_back(wpa ? vnd_id_cfg : rsn_id_cfg);
    rec_q.push_back(8'(len));
    foreach (body[i]) rec_q.push_back(body[i]);
  endtask

  task automatic put_rand_suite_elem();
    bit wpa;
    int pw_real, pw_claim, akm_real, akm_claim, len_adj, bad_hdr, r;
    logic [7:0] akm_t;
    wpa      = $urandom_range(0, 1);
    pw_real  = ($urandom_range(0, 39) == 0) ? $urandom_range(40, 55) : $urandom_range(0, 2);
    pw_claim = pw_real;
    r = $urandom_range(0, 15);
    if (r == 0) pw_claim = $urandom_range(0, 65535);
    else if (r == 1) pw_claim = pw_real + 1;
    akm_real  = $urandom_range(0, 2);
    akm_claim = akm_real;
    r = $urandom_range(0, 15);
    if (r == 0) akm_claim = -1;
    else if (r == 1) akm_claim = $urandom_range(0, 65535);
    else if (r == 2) akm_claim = akm_real + 1;
    r = $urandom_range(0, 9);
    if (r < 3) akm_t = AkmDot1x;
    else if (r < 5) akm_t = wsc_pkg::AkmPsk;
    else if (r < 7) akm_t = wsc_pkg::AkmFtPsk;
    else akm_t = 8'($urandom);
    len_adj = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 12)) - 8 : 0;
    bad_hdr = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1;
    put_suite_elem(wpa, pw_claim, pw_real, akm_claim, akm_real, $urandom_range(0, 2),
                   akm_t, $urandom_range(0, 3), len_adj, bad_hdr);
  endtask

  // one to three elements, now and then a lone trailing byte
  task automatic put_rand_elements();
    int r;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 99);
      if (r < 65) put_rand_suite_elem();
      else if (r < 98) put_other(8'($urandom), $urandom_range(0, 12));
      else put_other(8'($urandom), $urandom_range(200, 255));
    end
    if ($urandom_range(0, 9) == 0) rec_q.push_back(8'($urandom));
  endtask

  task automatic send_rand_record();
    int r;
    wsc_pkg::item_t it;
    if ($urandom_range(0, 9) == 0) tx_quiet = !tx_quiet;
    if ($urandom_range(0, 9) == 0) rx_quiet = !rx_quiet;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      put_rand_elements();
      send_record($urandom_range(0, 1), 1'b1);
    end else if (r < 84) begin
      // record whose first-byte flag is missing
      put_rand_elements();
      send_record($urandom_range(0, 1), 1'b0);
    end else if (r < 90) begin
      // byte that opens and closes a record
      rec_q.push_back(8'($urandom));
      send_record($urandom_range(0, 1), 1'b1);
    end else begin
      // loose bytes with random record flags
      repeat ($urandom_range(4, 20)) begin
        it.ie_byte     = 8'($urandom);
        it.privacy_bit = $urandom_range(0, 1);
        it.first_byte  = ($urandom_range(0, 5) == 0);
        it.last_byte   = ($urandom_range(0, 5) == 0);
        send_byte(it);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_register_access();
    apb_check(wsc_pkg::RegRsnId, wsc_pkg::RsnIdReset);
    apb_check(wsc_pkg::RegVndId, wsc_pkg::VndIdReset);
    set_ids(8'hff, 8'h00);
    set_ids(wsc_pkg::RsnIdReset, wsc_pkg::VndIdReset);
  endtask

  task automatic test_directed();
    // record of one byte, verdict from privacy alone
    rec_q.push_back(8'h00);
    send_record(1'b0, 1'b1);
    rec_q.push_back(8'hff);
    send_record(1'b1, 1'b1);
    // ssid only: open and wep
    put_other(8'h00, 4);
    send_record(1'b0, 1'b1);
    put_other(8'h00, 4);
    send_record(1'b1, 1'b1);
    // rsn psk, ft-psk and 802.1x
    put_suite_elem(1'b0, 1, 1, 1, 1, OuiSelIeee, wsc_pkg::AkmPsk, 2, 0, -1);
    send_record(1'b1, 1'b1);
    put_suite_elem(1'b0, 2, 2, 1, 1, OuiSelIeee, wsc_pkg::AkmFtPsk, 0, 0, -1);
    send_record(1'b0, 1'b1);
    put_suite_elem(1'b0, 1, 1, 2, 2, OuiSelIeee, AkmDot1x, 0, 0, -1);
    send_record(1'b1, 1'b1);
    // wpa psk and 802.1x
    put_suite_elem(1'b1, 1, 1, 1, 1, OuiSelMs, wsc_pkg::AkmPsk, 0, 0, -1);
    send_record(1'b1, 1'b1);
    put_suite_elem(1'b1, 1, 1, 1, 1, OuiSelMs, AkmDot1x, 0, 0, -1);
    send_record(1'b0, 1'b1);
    // vendor element with a spoiled oui keeps wep
    put_suite_elem(1'b1, 1, 1, 1, 1, OuiSelMs, wsc_pkg::AkmPsk, 0, 0, 1);
    send_record(1'b1, 1'b1);
    // vendor element too short to be wpa
    rec_q.push_back(vnd_id_cfg);
    rec_q.push_back(8'd3);
    rec_q.push_back(OuiByte0);
    rec_q.push_back(wsc_pkg::OuiMsB1);
    rec_q.push_back(wsc_pkg::OuiMsB2);
    send_record(1'b0, 1'b1);
    // zero-length rsn, then an ssid
    rec_q.push_back(rsn_id_cfg);
    rec_q.push_back(8'd0);
    put_other(8'h00, 2);
    send_record(1'b0, 1'b1);
    // rsn ending before its suite list
    put_other(rsn_id_cfg, 4);
    send_record(1'b1, 1'b1);
    // no akm list, akm count past the end, count but no suite
    put_suite_elem(1'b0, 1, 1, -1, 0, OuiSelIeee, wsc_pkg::AkmPsk, 0, 0, -1);
    send_record(1'b0, 1'b1);
    put_suite_elem(1'b0, 1, 1, 2, 1, OuiSelIeee, AkmDot1x, 0, 0, -1);
    send_record(1'b0, 1'b1);
    put_suite_elem(1'b0, 1, 1, 0, 0, OuiSelIeee, wsc_pkg::AkmPsk, 3, 0, -1);
    send_record(1'b0, 1'b1);
    // pairwise count with its high byte set
    put_suite_elem(1'b0, 16'h0101, 1, 1, 1, OuiSelIeee, AkmDot1x, 0, 0, -1);
    send_record(1'b0, 1'b1);
    // last element wins
    put_suite_elem(1'b0, 1, 1, 1, 1, OuiSelIeee, AkmDot1x, 0, 0, -1);
    put_suite_elem(1'b1, 1, 1, 1, 1, OuiSelMs, wsc_pkg::AkmPsk, 0, 0, -1);
    send_record(1'b0, 1'b1);
    // element cut short by the end of the record
    put_suite_elem(1'b0, 1, 1, 1, 1, OuiSelIeee, wsc_pkg::AkmPsk, 0, 0, -1);
    put_suite_elem(1'b0, 1, 1, 1, 1, OuiSelIeee, AkmDot1x, 0, 10, -1);
    send_record(1'b0, 1'b1);
    // lone trailing byte
    put_suite_elem(1'b1, 1, 1, 1, 1, OuiSelMs, AkmDot1x, 0, 0, -1);
    rec_q.push_back(8'h30);
    send_record(1'b0, 1'b1);
    // bytes after a last byte with no first byte
    put_suite_elem(1'b0, 1, 1, 1, 1, OuiSelIeee, wsc_pkg::AkmPsk, 0, 0, -1);
    send_record(1'b1, 1'b0);
    // longest element, then rsn
    put_other(8'hff, 255);
    put_suite_elem(1'b0, 0, 0, 1, 1, OuiSelRandom, wsc_pkg::AkmPsk, 0, 0, -1);
    send_record(1'b1, 1'b1);
    drain();
  endtask

  task automatic test_id_settings();
    logic [7:0] rsn_set[6];
    logic [7:0] vnd_set[6];
    int stop_at;
    // extremes, equal ids (rsn takes priority), swapped, random, back to reset
    rsn_set = '{8'h00, 8'hff, wsc_pkg::RsnIdReset, wsc_pkg::VndIdReset, 8'($urandom),
                wsc_pkg::RsnIdReset};
    vnd_set = '{8'hff, 8'h00, wsc_pkg::RsnIdReset, wsc_pkg::RsnIdReset, 8'($urandom),
                wsc_pkg::VndIdReset};
    for (int s = 0; s < 6; s++) begin
      set_ids(rsn_set[s], vnd_set[s]);
      stop_at = items_sent + 100;
      while (items_sent < stop_at) send_rand_record();
    end
    drain();
  endtask

  // receiver holds off while short records keep coming, so the block fills
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1)) begin
        rec_q.push_back(rsn_id_cfg);
        rec_q.push_back(8'd0);
      end else begin
        put_other(8'h00, $urandom_range(0, 1));
      end
      send_record($urandom_range(0, 1), 1'b1);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    drain();
  endtask

  task automatic test_random_records();
    int stop_at;
    stop_at = items_sent + 450;
    while (items_sent < stop_at) begin
      send_rand_record();
      if ($urandom_range(0, 19) == 0) drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_directed();
    test_id_settings();
    test_backpressure();
    test_random_records();
    drain();
    repeat (8) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* wlan_security_classifier.f */
sv/wsc_pkg.sv
sv/wsc_apb_regs.sv
sv/wsc_elem_parser.sv
sv/wlan_security_classifier.sv
tb/tb_top.sv
